### src/sgr_mouse_report_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// sgr mouse report decoder assertion macros
// shared concurrent assertion forms for the decoder modules
// ----------------------------------------------------------------------------
`ifndef SGR_MOUSE_REPORT_DECODER_UNIT_ASSERT_SVH
`define SGR_MOUSE_REPORT_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SGRMD_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgrmd assertion failed");

// next-cycle implication, checked outside reset
`define SGRMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgrmd assertion failed");

`endif

### src/sgrmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgrmd_pkg
// types, codes and sizes shared by the sgr mouse report decoder
// ----------------------------------------------------------------------------
package sgrmd_pkg;

   // field accumulator width and report length limit
   localparam int VALUE_WIDTH = 16;
   localparam int MAX_CHARS   = 48;
   localparam int COUNT_W     = 6;
   localparam int FIELD_COUNT = 3;
   localparam int COORD_W     = 16;

   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX =
      VALUE_WIDTH'((64'd1 << VALUE_WIDTH) - 64'd1);
   // largest field value that can still take one more digit
   localparam logic [VALUE_WIDTH-1:0] DIGIT_LIMIT = VALUE_WIDTH'((VALUE_MAX - 9) / 10);

   // request kinds
   localparam logic [1:0] REQ_START   = 2'd0;
   localparam logic [1:0] REQ_BYTE    = 2'd1;
   localparam logic [1:0] REQ_TIMEOUT = 2'd2;
   localparam logic [1:0] REQ_RESIZE  = 2'd3;

   // byte classes
   localparam logic [2:0] CLS_OTHER   = 3'd0;
   localparam logic [2:0] CLS_DIGIT   = 3'd1;
   localparam logic [2:0] CLS_SEMI    = 3'd2;
   localparam logic [2:0] CLS_PRESS   = 3'd3;
   localparam logic [2:0] CLS_RELEASE = 3'd4;

   // event kinds
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_RESIZE   = 3'd1;
   localparam logic [2:0] EV_BACK     = 3'd2;
   localparam logic [2:0] EV_FORWARD  = 3'd3;
   localparam logic [2:0] EV_LPRESS   = 3'd4;
   localparam logic [2:0] EV_LRELEASE = 3'd5;
   localparam logic [2:0] EV_WUP      = 3'd6;
   localparam logic [2:0] EV_WDOWN    = 3'd7;

   // button codes after the modifier bits are cleared
   localparam logic [VALUE_WIDTH-1:0] BTN_LEFT       = VALUE_WIDTH'(0);
   localparam logic [VALUE_WIDTH-1:0] BTN_WHEEL_UP   = VALUE_WIDTH'(64);
   localparam logic [VALUE_WIDTH-1:0] BTN_WHEEL_DOWN = VALUE_WIDTH'(65);
   localparam logic [VALUE_WIDTH-1:0] BTN_BACK       = VALUE_WIDTH'(128);
   localparam logic [VALUE_WIDTH-1:0] BTN_FORWARD    = VALUE_WIDTH'(129);
   localparam logic [VALUE_WIDTH-1:0] MOD_MASK       = VALUE_WIDTH'(28);

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] char_byte;
   } sgrmd_req_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [15:0] column;
      logic [15:0] row;
      logic        shift_held;
      logic        alt_held;
      logic        ctrl_held;
   } sgrmd_rsp_type;

   // classified request as held in the queue
   typedef struct packed {
      logic [1:0] req_kind;
      logic [2:0] cls;
      logic [3:0] digit;
   } sgrmd_item_type;

   typedef struct packed {
      logic           push;
      sgrmd_item_type item;
   } sgrmd_qwrite_type;

   typedef struct packed {
      logic           avail;
      sgrmd_item_type item;
   } sgrmd_qhead_type;

endpackage

### src/sgr_mouse_report_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_mouse_report_decoder_unit
// decoder for the body of an xterm sgr mouse report
// ----------------------------------------------------------------------------
// usage:
//   req channel: one request per handshake (req_valid high, req_stall low).
//   a start request opens a report, byte requests feed its characters,
//   timeout and resize requests close it. every report that ends gives
//   exactly one response on the rsp channel; an open report gives none.
//   rsp channel: event kind, zero-based column and row, modifier bits.
// path: a taken request is classified and written into the queue; the parser
//   consumes it from the queue head and registers its response in the
//   output register.
// throughput: one request per cycle while the queue is not full and the
//   response is not stalled, set by the digit accumulate (multiply by ten and add) in the parser.
// reset: queue emptied, no report open, no response pending.
// stall: a stalled response holds in the output register; the two-entry
//   queue keeps taking requests until it fills, then req_stall rises.
// ----------------------------------------------------------------------------
module sgr_mouse_report_decoder_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  sgrmd_pkg::sgrmd_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output sgrmd_pkg::sgrmd_rsp_type rsp_data
);

   // queue write side from the classifier
   sgrmd_pkg::sgrmd_qwrite_type qwrite;
   // queue head toward the parser
   sgrmd_pkg::sgrmd_qhead_type  qhead;
   logic                        queue_full;
   logic                        pop;

   // front: request handshake and byte classification
   sgrmd_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .qwrite     (qwrite)
   );

   // queue: decouples request intake from the parser
   sgrmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .qwrite     (qwrite),
      .queue_full (queue_full),
      .qhead      (qhead),
      .pop        (pop)
   );

   // back: report parser and output register
   sgrmd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .qhead     (qhead),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### src/sgrmd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgrmd_front
// accepts requests and classifies the received byte for the parser
// ----------------------------------------------------------------------------
module sgrmd_front (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sgrmd_pkg::sgrmd_req_type  req_data,
   input  logic                      queue_full,
   output sgrmd_pkg::sgrmd_qwrite_type qwrite
);

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_PRESS   = 8'h4D;
   localparam logic [7:0] CHAR_RELEASE = 8'h6D;

   logic [2:0] cls;

   always_comb begin
      if (req_data.char_byte >= CHAR_ZERO && req_data.char_byte <= CHAR_NINE) begin
         cls = sgrmd_pkg::CLS_DIGIT;
      end else if (req_data.char_byte == CHAR_SEMI) begin
         cls = sgrmd_pkg::CLS_SEMI;
      end else if (req_data.char_byte == CHAR_PRESS) begin
         cls = sgrmd_pkg::CLS_PRESS;
      end else if (req_data.char_byte == CHAR_RELEASE) begin
         cls = sgrmd_pkg::CLS_RELEASE;
      end else begin
         cls = sgrmd_pkg::CLS_OTHER;
      end
   end

   assign req_stall            = queue_full;
   assign qwrite.push          = req_valid && !queue_full;
   assign qwrite.item.req_kind = req_data.req_type;
   assign qwrite.item.cls      = cls;
   // low nibble of an ascii digit is its value
   assign qwrite.item.digit    = req_data.char_byte[3:0];

endmodule

### src/sgrmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgrmd_queue
// short request queue between the classifier and the parser
// ----------------------------------------------------------------------------
`include "sgr_mouse_report_decoder_unit_assert.svh"

module sgrmd_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  sgrmd_pkg::sgrmd_qwrite_type qwrite,
   output logic                        queue_full,
   output sgrmd_pkg::sgrmd_qhead_type  qhead,
   input  logic                        pop
);

   sgrmd_pkg::sgrmd_item_type entry_ff [sgrmd_pkg::QUEUE_DEPTH];

   logic [sgrmd_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sgrmd_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sgrmd_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                         empty;

   assign queue_full  = (count_ff == sgrmd_pkg::QCNT_W'(sgrmd_pkg::QUEUE_DEPTH));
   assign empty       = (count_ff == '0);
   assign qhead.avail = !empty;
   assign qhead.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (qwrite.push) begin
         wr_ptr_in = (wr_ptr_ff == sgrmd_pkg::QPTR_W'(sgrmd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == sgrmd_pkg::QPTR_W'(sgrmd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (qwrite.push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !qwrite.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (qwrite.push) begin
         entry_ff[wr_ptr_ff] <= qwrite.item;
      end
   end

   `SGRMD_ASSERT_HOLDS(a_count_bound, clock, reset, 1'b1,
      count_ff <= sgrmd_pkg::QCNT_W'(sgrmd_pkg::QUEUE_DEPTH))
   `SGRMD_ASSERT_HOLDS(a_no_push_full, clock, reset, queue_full, !qwrite.push)
   `SGRMD_ASSERT_HOLDS(a_no_pop_empty, clock, reset, empty, !pop)
   `SGRMD_ASSERT_NEXT(a_count_grows, clock, reset, qwrite.push && !pop,
      count_ff == $past(count_ff) + 1'b1)

endmodule

### src/sgrmd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgrmd_back
// report parser state and registered result stage
// ----------------------------------------------------------------------------
`include "sgr_mouse_report_decoder_unit_assert.svh"

module sgrmd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  sgrmd_pkg::sgrmd_qhead_type qhead,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output sgrmd_pkg::sgrmd_rsp_type   rsp_data
);

   localparam int VW = sgrmd_pkg::VALUE_WIDTH;

   logic                             in_report_ff, in_report_in;
   logic [1:0]                       field_index_ff, field_index_in;
   logic                             seen_digit_ff, seen_digit_in;
   logic [VW-1:0]                    field_values_ff [sgrmd_pkg::FIELD_COUNT];
   logic [VW-1:0]                    field_values_in [sgrmd_pkg::FIELD_COUNT];
   logic [sgrmd_pkg::COUNT_W-1:0]    byte_count_ff, byte_count_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   sgrmd_pkg::sgrmd_rsp_type         rsp_data_ff, rsp_data_in;

   sgrmd_pkg::sgrmd_item_type item;
   logic                      load;
   sgrmd_pkg::sgrmd_rsp_type  result;
   logic [1:0]                fi;
   logic [VW-1:0]             cur;
   logic [VW-1:0]             times_ten;
   logic [VW-1:0]             button;
   logic [VW-1:0]             x_minus_one;
   logic [VW-1:0]             y_minus_one;
   logic                      press;
   sgrmd_pkg::sgrmd_rsp_type  term_result;

   assign item = qhead.item;
   // output stage free now or emptied at this edge
   assign pop  = qhead.avail && (!rsp_valid_ff || !rsp_stall);

   assign fi        = (field_index_ff > 2'd2) ? 2'd2 : field_index_ff;
   assign cur       = field_values_ff[fi];
   assign times_ten = (cur << 3) + (cur << 1) + VW'(item.digit);

   // terminator decode
   assign press       = (item.cls == sgrmd_pkg::CLS_PRESS);
   assign button      = field_values_ff[0] & ~sgrmd_pkg::MOD_MASK;
   assign x_minus_one = field_values_ff[1] - 1'b1;
   assign y_minus_one = field_values_ff[2] - 1'b1;

   always_comb begin
      term_result = '0;
      if (field_values_ff[1] == '0 || field_values_ff[2] == '0) begin
         term_result.event_kind = sgrmd_pkg::EV_NONE;
      end else if (button == sgrmd_pkg::BTN_BACK || button == sgrmd_pkg::BTN_FORWARD) begin
         if (press) begin
            term_result.event_kind = (button == sgrmd_pkg::BTN_BACK) ?
                                     sgrmd_pkg::EV_BACK : sgrmd_pkg::EV_FORWARD;
         end
      end else if (button == sgrmd_pkg::BTN_LEFT ||
                   (press && (button == sgrmd_pkg::BTN_WHEEL_UP ||
                              button == sgrmd_pkg::BTN_WHEEL_DOWN))) begin
         if (button == sgrmd_pkg::BTN_LEFT) begin
            term_result.event_kind = press ? sgrmd_pkg::EV_LPRESS : sgrmd_pkg::EV_LRELEASE;
         end else if (button == sgrmd_pkg::BTN_WHEEL_UP) begin
            term_result.event_kind = sgrmd_pkg::EV_WUP;
         end else begin
            term_result.event_kind = sgrmd_pkg::EV_WDOWN;
         end
         term_result.column     = sgrmd_pkg::COORD_W'(x_minus_one);
         term_result.row        = sgrmd_pkg::COORD_W'(y_minus_one);
         term_result.shift_held = field_values_ff[0][2];
         term_result.alt_held   = field_values_ff[0][3];
         term_result.ctrl_held  = field_values_ff[0][4];
      end
   end

   always_comb begin
      in_report_in    = in_report_ff;
      field_index_in  = field_index_ff;
      seen_digit_in   = seen_digit_ff;
      field_values_in = field_values_ff;
      byte_count_in   = byte_count_ff;
      load            = 1'b0;
      result          = '0;
      if (pop) begin
         unique case (item.req_kind)
            sgrmd_pkg::REQ_START: begin
               // an open report ends with none, a fresh one opens
               load            = in_report_ff;
               in_report_in    = 1'b1;
               field_index_in  = 2'd0;
               seen_digit_in   = 1'b0;
               field_values_in = '{default: '0};
               byte_count_in   = '0;
            end
            sgrmd_pkg::REQ_TIMEOUT: begin
               load         = in_report_ff;
               in_report_in = 1'b0;
            end
            sgrmd_pkg::REQ_RESIZE: begin
               load              = in_report_ff;
               in_report_in      = 1'b0;
               result.event_kind = sgrmd_pkg::EV_RESIZE;
            end
            sgrmd_pkg::REQ_BYTE: begin
               if (in_report_ff) begin
                  byte_count_in = byte_count_ff + 1'b1;
                  priority if (item.cls == sgrmd_pkg::CLS_DIGIT) begin
                     if (cur > sgrmd_pkg::DIGIT_LIMIT) begin
                        load         = 1'b1;
                        in_report_in = 1'b0;
                     end else begin
                        field_values_in[fi] = times_ten;
                        seen_digit_in       = 1'b1;
                     end
                  end else if (item.cls == sgrmd_pkg::CLS_SEMI && seen_digit_ff &&
                               fi < 2'd2) begin
                     field_index_in = fi + 1'b1;
                     seen_digit_in  = 1'b0;
                  end else if ((item.cls == sgrmd_pkg::CLS_PRESS ||
                                item.cls == sgrmd_pkg::CLS_RELEASE) &&
                               fi == 2'd2 && seen_digit_ff) begin
                     load         = 1'b1;
                     in_report_in = 1'b0;
                     result       = term_result;
                  end else begin
                     load         = 1'b1;
                     in_report_in = 1'b0;
                  end
                  // length limit on a byte that kept the report open
                  if (!load && byte_count_in >= sgrmd_pkg::COUNT_W'(sgrmd_pkg::MAX_CHARS)) begin
                     load         = 1'b1;
                     in_report_in = 1'b0;
                  end
               end
            end
            default: begin
               load = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_report_ff   <= 1'b0;
         field_index_ff <= 2'd0;
         seen_digit_ff  <= 1'b0;
         byte_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         in_report_ff   <= in_report_in;
         field_index_ff <= field_index_in;
         seen_digit_ff  <= seen_digit_in;
         byte_count_ff  <= byte_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      field_values_ff <= field_values_in;
      rsp_data_ff     <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SGRMD_ASSERT_HOLDS(a_no_pop_stalled, clock, reset, rsp_valid_ff && rsp_stall, !pop)
   `SGRMD_ASSERT_HOLDS(a_field_index_range, clock, reset, in_report_ff,
      field_index_ff <= 2'd2)
   `SGRMD_ASSERT_HOLDS(a_count_below_limit, clock, reset, in_report_ff,
      byte_count_ff < sgrmd_pkg::COUNT_W'(sgrmd_pkg::MAX_CHARS))
   `SGRMD_ASSERT_NEXT(a_start_opens, clock, reset,
      pop && item.req_kind == sgrmd_pkg::REQ_START, in_report_ff && byte_count_ff == '0)

endmodule
